>>> hdl/smt_pkg.sv
// ----------------------------------------------------------------------------
// smt_pkg
// Types and constants shared by the set membership table and its checker.
// ----------------------------------------------------------------------------
package smt_pkg;

    localparam int DATA_W       = 32;
    localparam int COUNT_W      = 5;
    localparam int DEF_CAPACITY = 16;

    // Request kinds
    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_DELETE = 2'd1;
    localparam logic [1:0] KIND_QUERY  = 2'd2;
    localparam logic [1:0] KIND_LIST   = 2'd3;

    typedef struct packed {
        logic [1:0]               kind;
        logic signed [DATA_W-1:0] value;
    } smt_in_t;

    typedef struct packed {
        logic                     present;
        logic                     changed;
        logic                     full_error;
        logic [COUNT_W-1:0]       member_count;
        logic                     elem_valid;
        logic signed [DATA_W-1:0] elem_value;
        logic                     last;
    } smt_out_t;

    // Flags from the shared comparator
    typedef struct packed {
        logic eq;
        logic lt;
    } smt_cmp_t;

endpackage

>>> hdl/smt_cmp.sv
// ----------------------------------------------------------------------------
// smt_cmp
// Shared comparator: equality and signed less-than of a word read from the
// store against the current operand.
// ----------------------------------------------------------------------------
module smt_cmp (
    input  logic [smt_pkg::DATA_W-1:0] a,
    input  logic [smt_pkg::DATA_W-1:0] b,
    output smt_pkg::smt_cmp_t          flags
);
    import smt_pkg::*;

    assign flags.eq = (a == b);
    assign flags.lt = ($signed(a) < $signed(b));

endmodule

>>> hdl/set_membership_table_core.sv
// ----------------------------------------------------------------------------
// set_membership_table_core
// Set of distinct signed 32-bit values with insert, delete, query and a
// sorted listing, worked by a small sequencer around one comparator.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                 Payload
//  -------   -----------------------   ---------------------------------
//  request   start & !busy             req    (kind, value)
//  result    result_valid, one cycle   result (present ... last)
//
//  A listing makes one selection pass per member. Every scan reads the store
//  through its single read port, one word per cycle, feeding the shared
//  comparator.
//  Reset clears the member count; the store contents are not cleared, as
//  only entries below the count are ever read.
//  The receiver cannot stall: each result is shown for exactly one cycle.
//
module set_membership_table_core #(
    parameter int CAPACITY = smt_pkg::DEF_CAPACITY
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  smt_pkg::smt_in_t req,
    output logic             result_valid,
    output smt_pkg::smt_out_t result
);
    import smt_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SEARCH = 3'd1;
    localparam logic [2:0] ST_SHIFT  = 3'd2;
    localparam logic [2:0] ST_SORT   = 3'd3;
    localparam logic [2:0] ST_SWAP_A = 3'd4;
    localparam logic [2:0] ST_SWAP_B = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [1:0]        kind_reg, kind_next;
    logic [DATA_W-1:0] value_reg, value_next;
    logic [CNT_W-1:0]  scan_addr_reg, scan_addr_next;
    logic              pend_reg, pend_next;
    logic [AW-1:0]     pend_idx_reg, pend_idx_next;
    logic [CNT_W-1:0]  pass_reg, pass_next;
    logic [DATA_W-1:0] min_val_reg, min_val_next;
    logic [AW-1:0]     min_idx_reg, min_idx_next;
    logic [DATA_W-1:0] first_val_reg, first_val_next;
    logic              res_valid_reg, res_valid_next;
    smt_out_t          res_reg, res_next;

    logic [DATA_W-1:0] mem [CAPACITY];
    logic [DATA_W-1:0] rd_data_reg;
    logic              rd_en;
    logic              mem_we;
    logic [AW-1:0]     mem_wa;
    logic [DATA_W-1:0] mem_wd;

    logic [DATA_W-1:0] cmp_b;
    smt_cmp_t          cmp;
    logic              hit;
    logic              scan_more;
    logic [CNT_W-1:0]  pass_inc;
    logic              last_pass;

    function automatic logic [COUNT_W-1:0] count_field(input logic [CNT_W-1:0] c);
        logic [31:0] w;
        w = 32'(c);
        return w[COUNT_W-1:0];
    endfunction

    assign cmp_b = (state_reg == ST_SORT) ? min_val_reg : value_reg;

    smt_cmp u_cmp (
        .a     (rd_data_reg),
        .b     (cmp_b),
        .flags (cmp)
    );

    assign hit       = pend_reg && cmp.eq;
    assign scan_more = (scan_addr_reg < count_reg);
    assign pass_inc  = pass_reg + CNT_W'(1);
    assign last_pass = (pass_inc == count_reg);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        kind_next      = kind_reg;
        value_next     = value_reg;
        scan_addr_next = scan_addr_reg;
        pend_next      = 1'b0;
        pend_idx_next  = pend_idx_reg;
        pass_next      = pass_reg;
        min_val_next   = min_val_reg;
        min_idx_next   = min_idx_reg;
        first_val_next = first_val_reg;
        res_valid_next = 1'b0;
        res_next       = res_reg;
        rd_en          = 1'b0;
        mem_we         = 1'b0;
        mem_wa         = '0;
        mem_wd         = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    kind_next      = req.kind;
                    value_next     = req.value;
                    scan_addr_next = '0;
                    pass_next      = '0;
                    if (req.kind == KIND_LIST)
                    begin
                        if (count_reg == '0)
                        begin
                            // Listing an empty set gives one empty item.
                            res_valid_next        = 1'b1;
                            res_next              = '0;
                            res_next.member_count = count_field(count_reg);
                            res_next.last         = 1'b1;
                        end
                        else
                        begin
                            state_next = ST_SORT;
                        end
                    end
                    else
                    begin
                        state_next = ST_SEARCH;
                    end
                end
            end

            ST_SEARCH:
            begin
                if (hit || (!pend_reg && !scan_more))
                begin
                    res_next         = '0;
                    res_next.present = hit;
                    res_next.last    = 1'b1;
                    state_next       = ST_IDLE;
                    unique case (kind_reg)
                        KIND_INSERT:
                        begin
                            if (!hit)
                            begin
                                if (count_reg == CNT_W'(CAPACITY))
                                begin
                                    res_next.full_error = 1'b1;
                                end
                                else
                                begin
                                    mem_we           = 1'b1;
                                    mem_wa           = count_reg[AW-1:0];
                                    mem_wd           = value_reg;
                                    count_next       = count_reg + CNT_W'(1);
                                    res_next.changed = 1'b1;
                                end
                            end
                        end
                        KIND_DELETE:
                        begin
                            if (hit)
                            begin
                                // Close the gap by moving later entries down.
                                state_next     = ST_SHIFT;
                                scan_addr_next = CNT_W'(pend_idx_reg) + CNT_W'(1);
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    res_valid_next        = (state_next == ST_IDLE);
                    res_next.member_count = count_field(count_next);
                end
                else if (scan_more)
                begin
                    rd_en          = 1'b1;
                    pend_next      = 1'b1;
                    pend_idx_next  = scan_addr_reg[AW-1:0];
                    scan_addr_next = scan_addr_reg + CNT_W'(1);
                end
            end

            ST_SHIFT:
            begin
                if (pend_reg)
                begin
                    mem_we = 1'b1;
                    mem_wa = pend_idx_reg - AW'(1);
                    mem_wd = rd_data_reg;
                end
                if (scan_more)
                begin
                    rd_en          = 1'b1;
                    pend_next      = 1'b1;
                    pend_idx_next  = scan_addr_reg[AW-1:0];
                    scan_addr_next = scan_addr_reg + CNT_W'(1);
                end
                else if (!pend_reg)
                begin
                    count_next            = count_reg - CNT_W'(1);
                    res_valid_next        = 1'b1;
                    res_next              = '0;
                    res_next.present      = 1'b1;
                    res_next.changed      = 1'b1;
                    res_next.member_count = count_field(count_next);
                    res_next.last         = 1'b1;
                    state_next            = ST_IDLE;
                end
            end

            ST_SORT:
            begin
                if (pend_reg)
                begin
                    if (pend_idx_reg == pass_reg[AW-1:0])
                    begin
                        min_val_next   = rd_data_reg;
                        min_idx_next   = pend_idx_reg;
                        first_val_next = rd_data_reg;
                    end
                    else if (cmp.lt)
                    begin
                        min_val_next = rd_data_reg;
                        min_idx_next = pend_idx_reg;
                    end
                end
                if (scan_more)
                begin
                    rd_en          = 1'b1;
                    pend_next      = 1'b1;
                    pend_idx_next  = scan_addr_reg[AW-1:0];
                    scan_addr_next = scan_addr_reg + CNT_W'(1);
                end
                else if (!pend_reg)
                begin
                    state_next = ST_SWAP_A;
                end
            end

            ST_SWAP_A:
            begin
                // The smallest remaining member goes to the head of the pass.
                mem_we                = 1'b1;
                mem_wa                = pass_reg[AW-1:0];
                mem_wd                = min_val_reg;
                res_valid_next        = 1'b1;
                res_next              = '0;
                res_next.member_count = count_field(count_reg);
                res_next.elem_valid   = 1'b1;
                res_next.elem_value   = min_val_reg;
                res_next.last         = last_pass;
                state_next            = ST_SWAP_B;
            end

            ST_SWAP_B:
            begin
                mem_we = 1'b1;
                mem_wa = min_idx_reg;
                mem_wd = first_val_reg;
                if (last_pass)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    pass_next      = pass_inc;
                    scan_addr_next = pass_inc;
                    state_next     = ST_SORT;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        value_reg     <= value_next;
        scan_addr_reg <= scan_addr_next;
        pend_idx_reg  <= pend_idx_next;
        pass_reg      <= pass_next;
        min_val_reg   <= min_val_next;
        min_idx_reg   <= min_idx_next;
        first_val_reg <= first_val_next;
        res_reg       <= res_next;
    end

    // Member store: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[scan_addr_reg[AW-1:0]];
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

>>> hdl/smt_check.sv
// ----------------------------------------------------------------------------
// smt_check
// Port-level checks for the set membership table, bound to the top level.
// ----------------------------------------------------------------------------
module smt_check #(
    parameter int CAPACITY = smt_pkg::DEF_CAPACITY
) (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input smt_pkg::smt_in_t  req,
    input logic              result_valid,
    input smt_pkg::smt_out_t result
);
    import smt_pkg::*;

    localparam int                 FULL_MOD = CAPACITY % 32;
    localparam logic [COUNT_W-1:0] FULL_CNT = COUNT_W'(FULL_MOD);

    // Any item other than a listing keeps the block occupied while it scans.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (req.kind != KIND_LIST) |=> busy)
        else $error("block not busy after accepting an item");

    // More results of a listing are still to come.
    a_busy_until_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last |-> busy)
        else $error("block idle before the last result");

    // Only listing items carry members; every other result stands alone.
    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.elem_valid |-> result.last)
        else $error("result without member is not the last");

    // A refused insert leaves the store full and unchanged.
    a_full_refusal: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.full_error |->
            !result.changed && !result.present && (result.member_count == FULL_CNT))
        else $error("inconsistent full refusal");

endmodule

bind set_membership_table_core smt_check #(.CAPACITY(CAPACITY)) u_smt_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .req          (req),
    .result_valid (result_valid),
    .result       (result)
);

>>> tb/sv/set_table_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_table_checker
// Watches the request and result channels of the set membership table. It
// keeps its own copy of the member store, works out the results that each
// accepted item should cause, and compares every result field by field with
// the oldest one still expected.
// ----------------------------------------------------------------------------
module set_table_checker #(
    parameter int CAPACITY = smt_pkg::DEF_CAPACITY
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  smt_pkg::smt_in_t  req,
    input  logic              result_valid,
    input  smt_pkg::smt_out_t result,
    output int                pending,
    output int                mismatches
);
    import smt_pkg::*;

    logic signed [DATA_W-1:0] members [CAPACITY];
    int                       member_total;
    smt_out_t                 expected_results [$];
    smt_out_t                 want;

    function automatic string show_result(input smt_out_t r);
        return $sformatf({"present=%0b changed=%0b full=%0b count=%0d ",
                          "evalid=%0b evalue=%0d last=%0b"},
                         r.present, r.changed, r.full_error, r.member_count,
                         r.elem_valid, r.elem_value, r.last);
    endfunction

    // Applies one item to the local store and queues the results it causes.
    task automatic predict_set_op(input smt_in_t item);
        smt_out_t                 r;
        logic signed [DATA_W-1:0] ordered [CAPACITY];
        logic signed [DATA_W-1:0] held;
        int                       hit;
        int                       i;
        int                       j;
        r      = '0;
        r.last = 1'b1;
        if (item.kind == KIND_LIST) begin
            if (member_total == 0) begin
                expected_results.push_back(r);
            end
            else begin
                for (i = 0; i < member_total; i++)
                    ordered[i] = members[i];
                // Insertion sort; both operands are signed, so the order is signed.
                for (i = 1; i < member_total; i++)
                begin
                    held = ordered[i];
                    j    = i - 1;
                    while (j >= 0 && ordered[j] > held)
                    begin
                        ordered[j + 1] = ordered[j];
                        j--;
                    end
                    ordered[j + 1] = held;
                end
                for (i = 0; i < member_total; i++)
                begin
                    r              = '0;
                    r.member_count = COUNT_W'(member_total);
                    r.elem_valid   = 1'b1;
                    r.elem_value   = ordered[i];
                    r.last         = (i == member_total - 1);
                    expected_results.push_back(r);
                end
            end
        end
        else begin
            hit = -1;
            for (i = 0; i < member_total; i++)
                if (hit < 0 && members[i] == item.value)
                    hit = i;
            case (item.kind)
                KIND_INSERT:
                begin
                    if (hit >= 0) begin
                        r.present = 1'b1;
                    end
                    else if (member_total >= CAPACITY) begin
                        r.full_error = 1'b1;
                    end
                    else begin
                        members[member_total] = item.value;
                        member_total++;
                        r.changed = 1'b1;
                    end
                end
                KIND_DELETE:
                begin
                    if (hit >= 0) begin
                        // The store stays compacted at the low entries.
                        for (i = hit; i + 1 < member_total; i++)
                            members[i] = members[i + 1];
                        member_total--;
                        r.present = 1'b1;
                        r.changed = 1'b1;
                    end
                end
                default:
                    r.present = (hit >= 0);
            endcase
            r.member_count = COUNT_W'(member_total);
            expected_results.push_back(r);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            member_total = 0;
            expected_results.delete();
            pending    = 0;
            mismatches = 0;
        end
        else begin
            if (start === 1'b1 && busy === 1'b0)
                predict_set_op(req);
            if (result_valid === 1'b1) begin
                if (expected_results.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: result with nothing expected: %s",
                                 $realtime, show_result(result));
                    mismatches++;
                end
                else begin
                    want = expected_results.pop_front();
                    if (result.present !== want.present || result.changed !== want.changed ||
                        result.full_error !== want.full_error ||
                        result.member_count !== want.member_count ||
                        result.elem_valid !== want.elem_valid ||
                        result.elem_value !== want.elem_value || result.last !== want.last)
                    begin
                        if (mismatches < 10) begin
                            $display("%0t: result mismatch", $realtime);
                            $display("    expected %s", show_result(want));
                            $display("    actual   %s", show_result(result));
                        end
                        mismatches++;
                    end
                end
            end
            pending = expected_results.size();
        end
    end

endmodule

>>> tb/sv/tb_set_membership_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_set_membership_table_core
// Drives insert, delete, query and list items into the set membership table:
// a directed opening on the extremes and corner cases, then phases of random
// items that alternately fill and drain the set, with and without idle gaps.
// The checker beside the block reports the failures; this module decides.
// ----------------------------------------------------------------------------
module tb_set_membership_table_core;
    import smt_pkg::*;

    localparam int CAPACITY         = DEF_CAPACITY;
    localparam int CYCLE_LIMIT      = 600000;
    localparam int TAIL_CYCLES      = 40;
    localparam int ITEMS_PER_PHASE  = 110;
    localparam int POOL_DEPTH       = 20;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    smt_in_t  req;
    logic     result_valid;
    smt_out_t result;
    int       pending;
    int       mismatches;
    int       cycle_count;
    int       gap_pct;

    // Values that are probably members, so that deletes and queries hit.
    logic signed [DATA_W-1:0] live_values [$];

    set_membership_table_core #(
        .CAPACITY (CAPACITY)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req          (req),
        .result_valid (result_valid),
        .result       (result)
    );

    set_table_checker #(
        .CAPACITY (CAPACITY)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req          (req),
        .result_valid (result_valid),
        .result       (result),
        .pending      (pending),
        .mismatches   (mismatches)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial cycle_count = 0;

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb_set_membership_table_core: FAIL");
        $finish;
    end

    // Presents one item, holding it until the block takes it.
    task automatic send_request(input logic [1:0] op, input logic signed [DATA_W-1:0] operand);
        smt_in_t item;
        int      idle;
        int      at;
        int      i;
        item.kind  = op;
        item.value = operand;
        idle = 0;
        if (gap_pct > 0 && $urandom_range(99) < gap_pct)
            idle = $urandom_range(1, 8);
        if (idle > 0) begin
            start <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        req   <= item;
        start <= 1'b1;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        at = -1;
        for (i = 0; i < live_values.size(); i++)
            if (live_values[i] == operand)
                at = i;
        if (op == KIND_INSERT && at < 0) begin
            live_values.push_back(operand);
            if (live_values.size() > POOL_DEPTH)
                void'(live_values.pop_front());
        end
        if (op == KIND_DELETE && at >= 0)
            live_values.delete(at);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int                       phase;
        int                       n;
        int                       roll;
        logic [1:0]               op;
        logic signed [DATA_W-1:0] operand;

        rst_n   <= 1'b0;
        start   <= 1'b0;
        req     <= '0;
        gap_pct = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening: empty set, extreme values, duplicates, compaction,
        // a full store and a full listing.
        send_request(KIND_LIST,   32'sd0);
        send_request(KIND_QUERY,  32'sd0);
        send_request(KIND_DELETE, 32'sd5);
        send_request(KIND_INSERT, {1'b1, 31'd0});
        send_request(KIND_INSERT, {1'b0, {31{1'b1}}});
        send_request(KIND_INSERT, 32'sd0);
        send_request(KIND_INSERT, -32'sd1);
        send_request(KIND_INSERT, {1'b0, {31{1'b1}}});
        send_request(KIND_QUERY,  {1'b1, 31'd0});
        send_request(KIND_DELETE, 32'sd0);
        send_request(KIND_DELETE, 32'sd0);
        send_request(KIND_LIST,   -32'sd1);
        for (n = 0; n < CAPACITY - 3; n++)
            send_request(KIND_INSERT, $urandom);
        send_request(KIND_INSERT, 32'sd12345);
        send_request(KIND_INSERT, -32'sd1);
        send_request(KIND_LIST,   32'sd0);
        // Hold off until every result of the opening has come back.
        wait_drained();

        // Even phases lean towards inserts and fill the store; odd ones drain it.
        for (phase = 0; phase < 4; phase++)
        begin
            gap_pct = (phase == 1) ? 68 : (phase == 3) ? 29 : 0;
            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                roll = $urandom_range(99);
                if (phase % 2 == 0)
                    op = (roll < 55) ? KIND_INSERT : (roll < 70) ? KIND_DELETE :
                         (roll < 85) ? KIND_QUERY : KIND_LIST;
                else
                    op = (roll < 15) ? KIND_INSERT : (roll < 70) ? KIND_DELETE :
                         (roll < 85) ? KIND_QUERY : KIND_LIST;
                roll = $urandom_range(99);
                if (live_values.size() > 0 && roll < ((op == KIND_INSERT) ? 20 : 75))
                    operand = live_values[$urandom_range(live_values.size() - 1)];
                else if (roll >= 90)
                    case ($urandom_range(3))
                        0:       operand = {1'b1, 31'd0};
                        1:       operand = {1'b0, {31{1'b1}}};
                        2:       operand = 32'sd0;
                        default: operand = -32'sd1;
                    endcase
                else
                    operand = $urandom;
                send_request(op, operand);
            end
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("tb_set_membership_table_core: PASS");
        else
            $display("tb_set_membership_table_core: FAIL");
        $finish;
    end

endmodule

>>> sim.f
hdl/smt_pkg.sv
hdl/smt_cmp.sv
hdl/set_membership_table_core.sv
hdl/smt_check.sv
tb/sv/set_table_checker.sv
tb/sv/tb_set_membership_table_core.sv
